FILE: rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types and constants for the alpha-over blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int NUM_STAGES = 11;               // front stages plus divider stages
    localparam int DIV_FIRST  = 3;                // first divider stage
    localparam int QUOT_BITS  = 8;                // quotient bits, one per divider stage
    localparam logic [15:0] STRIDE_RESET = 16'd640;
    localparam logic [15:0] RECIP_255    = 16'h8081;  // x/255 == (x*RECIP_255)>>23 for 16-bit x

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic [31:0]       addr;
        logic [7:0]        s;      // effective source alpha
        logic [7:0]        da;
        logic [2:0][7:0]   cs;
        logic [2:0][7:0]   cd;
        logic [2:0][15:0]  t1;     // cs * s
        logic [15:0]       u;      // da * (255 - s)
        logic [15:0]       den;
        logic [7:0]        alpha;
        logic [2:0][23:0]  rem;
        logic [2:0][7:0]   q;
    } t_stage;

endpackage

FILE: rtl/alpha_over_blend_top.sv
// ----------------------------------------------------------------------------
// alpha_over_blend_top
// Porter-Duff over blend on straight-alpha RGBA8888 with pixel address.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output side does not stall and returns
// one word per word, in order, through three front stages (weighted alpha
// and address multiply, channel and denominator products, numerator and
// alpha reciprocal) and eight restoring divider stages that each resolve
// one quotient bit of every color channel. Each stage holds its own valid
// bit and advances when empty or when the stage after it advances, so
// bubbles close up under back-pressure and the input keeps accepting while
// a result waits on the output. The stride register is written with
// i_cfg_wr_en; write it only while the pipeline is empty. A zero blend
// denominator (both alphas zero) gives an all-zero pixel.
module alpha_over_blend_top
    import aob_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [15:0]           i_cfg_wr_data,   // line_stride_words
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pos_x[15:0], pos_y[31:16], dest_pixel[63:32], src_red[71:64],
    // src_green[79:72], src_blue[87:80], src_alpha[95:88],
    // alpha_weight[104:96], zero pad[111:105]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tuser,  // use_weight
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // word_address[31:0], blended_pixel[63:32]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [15:0]               r_stride;
    t_stage                    r_pipe [NUM_STAGES];
    t_stage                    n_pipe [NUM_STAGES];
    logic [NUM_STAGES-1:0]     r_v;
    logic [NUM_STAGES-1:0]     adv;

    // Stage-front decode of the input word
    logic [15:0] in_x, in_y;
    logic [31:0] in_dst;
    logic [7:0]  in_sa;
    logic [8:0]  in_w;
    logic [16:0] w_prod;
    logic [8:0]  w_shift;

    assign in_x   = i_s_axis_tdata[15:0];
    assign in_y   = i_s_axis_tdata[31:16];
    assign in_dst = i_s_axis_tdata[63:32];
    assign in_sa  = i_s_axis_tdata[95:88];
    assign in_w   = i_s_axis_tdata[104:96];
    assign w_prod  = 17'(in_sa) * 17'(in_w);
    assign w_shift = w_prod[16:8];

    // Hold a stage when it is full and the next one is held
    always_comb begin
        adv[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_s_axis_tready = adv[0];

    always_comb begin
        logic [7:0]  ns;
        logic [15:0] s255;
        logic [23:0] trial;
        logic [31:0] rprod;
        int          b;

        for (int k = 0; k < NUM_STAGES; k++) begin
            n_pipe[k] = (k == 0) ? r_pipe[0] : r_pipe[k-1];
        end

        // Stage 0: effective alpha and pixel address
        ns = (i_s_axis_tuser) ? ((w_shift > 9'd255) ? 8'd255 : w_shift[7:0]) : in_sa;
        n_pipe[0].s    = ns;
        n_pipe[0].da   = in_dst[31:24];
        n_pipe[0].cd   = in_dst[23:0];
        n_pipe[0].cs   = i_s_axis_tdata[87:64];
        n_pipe[0].addr = 32'(in_y) * 32'(r_stride) + 32'(in_x);

        // Stage 1: source products and denominator
        for (int c = 0; c < 3; c++) begin
            n_pipe[1].t1[c] = 16'(r_pipe[0].cs[c]) * 16'(r_pipe[0].s);
        end
        n_pipe[1].u   = 16'(r_pipe[0].da) * 16'(8'd255 - r_pipe[0].s);
        s255          = {r_pipe[0].s, 8'd0} - 16'(r_pipe[0].s);
        n_pipe[1].den = s255 + 16'(r_pipe[0].da) * 16'(8'd255 - r_pipe[0].s);

        // Stage 2: numerators and output alpha
        for (int c = 0; c < 3; c++) begin
            n_pipe[2].rem[c] = ({r_pipe[1].t1[c], 8'd0} - 24'(r_pipe[1].t1[c]))
                             + 24'(r_pipe[1].cd[c]) * 24'(r_pipe[1].u);
            n_pipe[2].q[c]   = '0;
        end
        rprod           = 32'(r_pipe[1].den) * 32'(RECIP_255);
        n_pipe[2].alpha = rprod[30:23];

        // Divider stages: one quotient bit per stage, MSB first
        for (int k = DIV_FIRST; k < NUM_STAGES; k++) begin
            b = QUOT_BITS - 1 - (k - DIV_FIRST);
            for (int c = 0; c < 3; c++) begin
                trial = 24'(r_pipe[k-1].den) << b;
                if (r_pipe[k-1].rem[c] >= trial) begin
                    n_pipe[k].rem[c]  = r_pipe[k-1].rem[c] - trial;
                    n_pipe[k].q[c][b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
            r_v      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_stride <= i_cfg_wr_data;
            end
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= (k == 0) ? i_s_axis_tvalid : r_v[k-1];
                end
            end
        end
    end

    // Payload advances with its stage; no reset needed
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    // Drop color and alpha to zero when the denominator vanished
    assign o_m_axis_tvalid = r_v[NUM_STAGES-1];
    assign o_m_axis_tdata[31:0]  = r_pipe[NUM_STAGES-1].addr;
    assign o_m_axis_tdata[63:32] = (r_pipe[NUM_STAGES-1].den == 16'd0) ? 32'd0 :
        {r_pipe[NUM_STAGES-1].alpha, r_pipe[NUM_STAGES-1].q[2],
         r_pipe[NUM_STAGES-1].q[1], r_pipe[NUM_STAGES-1].q[0]};

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alpha-over blend pipeline.
// ----------------------------------------------------------------------------
// Predicts address and blended pixel for every accepted word, queues the
// prediction and compares each output word in order. Covers directed corner
// pixels, several strides, random traffic under three idle mixes and a long
// output stall that fills the pipeline.
module tb;
    import aob_pkg::*;

    // Same layout as the output word: address low, pixel high
    typedef struct packed {
        logic [31:0] pixel;
        logic [31:0] addr;
    } t_blend_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [15:0]           i_cfg_wr_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // pos_x, pos_y, dest_pixel, src r/g/b/a, alpha_weight, pad (low bit up)
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;  // use_weight
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // word_address, blended_pixel (low bit up)
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    logic [15:0]  stride = STRIDE_RESET;
    t_blend_out   pending_pixels[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_output = 1'b0;
    int           mismatches = 0;
    int           words_in = 0;
    int           words_out = 0;
    int           quiet_cycles = 0;

    localparam int QUIET_LIMIT = 20000;

    alpha_over_blend_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Exact integer form of straight-alpha over, truncated and clamped.
    function automatic t_blend_out blend_pixel(logic [111:0] d, logic uw);
        t_blend_out r;
        logic [31:0] dst;
        logic [63:0] s, da, den, num, q;
        logic [31:0] pix;
        dst = d[63:32];
        da  = dst[31:24];
        s   = d[95:88];
        if (uw) begin
            s = (s * d[104:96]) >> 8;
            if (s > 255) s = 255;
        end
        den = 255 * s + da * (255 - s);
        pix = '0;
        if (den != 0) begin
            for (int c = 0; c < 3; c++) begin
                num = 255 * d[64 + 8*c +: 8] * s + dst[8*c +: 8] * da * (255 - s);
                q = num / den;
                pix[8*c +: 8] = (q > 255) ? 8'd255 : q[7:0];
            end
            q = den / 255;
            pix[31:24] = (q > 255) ? 8'd255 : q[7:0];
        end
        r.addr  = d[31:16] * {16'd0, stride} + d[15:0];
        r.pixel = pix;
        return r;
    endfunction

    // Valid stays up between back-to-back words; drop it only while idling.
    task automatic send_pixel(logic [15:0] x, logic [15:0] y, logic [31:0] dst,
                              logic [31:0] src, logic [8:0] w, logic uw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tdata  <= {7'd0, w, src, dst, y, x};
        i_s_axis_tuser  <= uw;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_pixels.push_back(blend_pixel({7'd0, w, src, dst, y, x}, uw));
        words_in++;
    endtask

    task automatic send_random;
        logic [31:0] src, dst;
        src = $urandom;
        dst = $urandom;
        // bias alphas toward the edges where the blend is interesting
        case ($urandom_range(3))
            0: dst[31:24] = 8'd0;
            1: src[31:24] = $urandom_range(1) ? 8'd255 : 8'd0;
            default: ;
        endcase
        send_pixel(16'($urandom), 16'($urandom), dst, src, 9'($urandom_range(511)),
                   1'($urandom_range(1)));
    endtask

    // Wait for the pipeline to drain before touching the stride.
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (NUM_STAGES + 4) @(posedge i_clk);
    endtask

    task automatic write_stride(logic [15:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        stride = v;
    endtask

    task automatic test_corners;
        send_pixel(16'h0, 16'h0, 32'h0, 32'h0, 9'd0, 1'b0);           // both alphas zero
        send_pixel(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'h1FF, 1'b1);
        send_pixel(16'd5, 16'd7, 32'h80402010, 32'hFF112233, 9'd256, 1'b1);
        send_pixel(16'd1, 16'd1, 32'hFF102030, 32'h00AABBCC, 9'd0, 1'b0); // clear source
        send_pixel(16'd2, 16'd3, 32'h00102030, 32'h40AABBCC, 9'd0, 1'b0); // clear dest
        send_pixel(16'd9, 16'd9, 32'h7F55AA33, 32'hC0123456, 9'd300, 1'b1); // weight > 256
        send_pixel(16'd9, 16'd9, 32'h7F55AA33, 32'hC0123456, 9'd511, 1'b1);
        send_pixel(16'd9, 16'd9, 32'h7F55AA33, 32'hC0123456, 9'd128, 1'b1);
        send_pixel(16'hAAAA, 16'h5555, 32'h01FF00FF, 32'h01FF00FF, 9'd0, 1'b0);
        send_pixel(16'h5555, 16'hAAAA, 32'hFE00FF00, 32'hFE00FF00, 9'h0AA, 1'b1);
        send_pixel(16'd0, 16'd0, 32'hFF000000, 32'h00FFFFFF, 9'd1, 1'b1);
    endtask

    task automatic test_strides;
        logic [15:0] vals[4] = '{16'd0, 16'd1, 16'hFFFF, 16'd1920};
        foreach (vals[i]) begin
            write_stride(vals[i]);
            send_pixel(16'hFFFF, 16'hFFFF, 32'h80808080, 32'h80808080, 9'd0, 1'b0);
            send_pixel(16'd3, 16'd2, 32'h0, 32'hFF000000, 9'd256, 1'b1);
            repeat (20) send_random();
        end
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) begin
            if ($urandom_range(19) == 0) write_stride(16'($urandom));
            send_random();
        end
    endtask

    // Hold the output off while the input keeps offering words.
    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_output = 1'b1;
        repeat (40) send_random();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_strides();
        test_random(160, 13, 58);
        test_random(160, 58, 13);
        test_random(160, 0, 0);
        test_backpressure();
        drain();
        $display("Sent %0d pixels, checked %0d, across many strides and three idle mixes,",
                 words_in, words_out);
        $display("including a long output stall that filled the pipeline.");
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Long stall: count cycles on its own, then release the output.
    always @(posedge i_clk) begin
        if (hold_output) begin
            repeat (60) @(posedge i_clk);
            hold_output = 1'b0;
        end
    end

    // Output side: random ready, drop to zero during the long stall.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each output word with the oldest prediction.
    always @(posedge i_clk) begin
        t_blend_out want;
        t_blend_out got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            words_out++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.addr !== want.addr || got.pixel !== want.pixel) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: addr exp %h got %h, pixel exp %h got %h",
                                 want.addr, got.addr, want.pixel, got.pixel);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (pending_pixels.size() == 0 && !i_s_axis_tvalid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout with %0d words outstanding", pending_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end
endmodule

FILE: sim.f
rtl/aob_pkg.sv
rtl/alpha_over_blend_top.sv
bench/tb.sv
